// ===== src/itoa_pkg.sv =====
// Package for the integer-to-ASCII formatter: field widths, format codes,
// character constants and the command and status types shared by its modules.
// Depends on nothing.
package itoa_pkg;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 7;
   localparam int COUNT_W  = 4;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W    = 4 * BCD_DIGITS;
   localparam int CNT_W    = 6;

   localparam logic [FUNC_W-1:0] FMT_BIN  = 3'd0;
   localparam logic [FUNC_W-1:0] FMT_HEXP = 3'd1;
   localparam logic [FUNC_W-1:0] FMT_HEX  = 3'd2;
   localparam logic [FUNC_W-1:0] FMT_SDEC = 3'd3;
   localparam logic [FUNC_W-1:0] FMT_UDEC = 3'd4;

   localparam logic [CNT_W-1:0] CNT_BIN  = 6'd32;
   localparam logic [CNT_W-1:0] CNT_HEX  = 6'd8;
   localparam logic [CNT_W-1:0] CNT_CONV = 6'd32;
   localparam logic [CNT_W-1:0] CNT_DEC  = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A_LC  = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_X_LC  = 7'h78;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
   localparam logic [3:0]        HEX_TEN    = 4'd10;

   typedef logic [2:0] emit_type;
   localparam emit_type EMIT_NONE  = 3'd0;
   localparam emit_type EMIT_ZERO  = 3'd1;
   localparam emit_type EMIT_X     = 3'd2;
   localparam emit_type EMIT_MINUS = 3'd3;
   localparam emit_type EMIT_DIGIT = 3'd4;

   typedef struct packed {
      logic     load;
      logic     conv;
      emit_type emit_kind;
   } itoa_cmd_type;

   typedef struct packed {
      logic can_load;
      logic cnt_one;
      logic neg;
   } itoa_sts_type;

endpackage

// ===== src/itoa_req_if.sv =====
// Request channel of the integer-to-ASCII formatter: valid, ready and payload.
// Depends on itoa_pkg for the field widths.
interface itoa_req_if;
   logic                          valid;
   logic                          ready;
   logic [itoa_pkg::FUNC_W-1:0]   func;
   logic [itoa_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== src/itoa_rsp_if.sv =====
// Response channel of the integer-to-ASCII formatter: valid, ready and payload.
// Depends on itoa_pkg for the field widths.
interface itoa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itoa_pkg::CHAR_W-1:0]   character;
   logic                          is_last;
   logic [itoa_pkg::COUNT_W-1:0]  digit_count;

   modport source (output valid, output character, output is_last, output digit_count,
                   input ready);
   modport sink   (input valid, input character, input is_last, input digit_count,
                   output ready);
endinterface

// ===== src/itoa_ctrl.sv =====
// Controller state machine of the integer-to-ASCII formatter.
// Depends on itoa_pkg; drives the datapath itoa_dp through command signals.
module itoa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [itoa_pkg::FUNC_W-1:0] req_func,
   output logic                        req_ready,
   input  itoa_pkg::itoa_sts_type      sts,
   output itoa_pkg::itoa_cmd_type      cmd
);
   import itoa_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PFX0   = 3'd1;
   localparam logic [2:0] ST_PFXX   = 3'd2;
   localparam logic [2:0] ST_CONV   = 3'd3;
   localparam logic [2:0] ST_SIGN   = 3'd4;
   localparam logic [2:0] ST_DIGITS = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.conv      = 1'b0;
      cmd.emit_kind = EMIT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_func)
                  FMT_BIN:  state_in = ST_DIGITS;
                  FMT_HEXP: state_in = ST_PFX0;
                  FMT_HEX:  state_in = ST_DIGITS;
                  FMT_SDEC: state_in = ST_CONV;
                  FMT_UDEC: state_in = ST_CONV;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_PFX0: begin
            if (sts.can_load) begin
               cmd.emit_kind = EMIT_ZERO;
               state_in      = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (sts.can_load) begin
               cmd.emit_kind = EMIT_X;
               state_in      = ST_DIGITS;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (sts.cnt_one) begin
               state_in = sts.neg ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (sts.can_load) begin
               cmd.emit_kind = EMIT_MINUS;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (sts.can_load) begin
               cmd.emit_kind = EMIT_DIGIT;
               if (sts.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/itoa_dp.sv =====
// Datapath of the integer-to-ASCII formatter: double-dabble converter, digit
// shifter with zero suppression and the response output register.
// Depends on itoa_pkg; commanded by itoa_ctrl.
module itoa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [itoa_pkg::FUNC_W-1:0]   req_func,
   input  logic [itoa_pkg::VALUE_W-1:0]  req_value,
   input  itoa_pkg::itoa_cmd_type        cmd,
   output itoa_pkg::itoa_sts_type        sts,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]   rsp_character,
   output logic                          rsp_is_last,
   output logic [itoa_pkg::COUNT_W-1:0]  rsp_digit_count
);
   import itoa_pkg::*;

   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   dig_ff, dig_in;
   logic [BCD_W-1:0]   adj;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               bin_mode_ff, bin_mode_in;
   logic               on_ff, on_in;
   logic [COUNT_W-1:0] ndig_ff, ndig_in;
   logic               neg_ff, neg_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic [3:0]         digit;
   logic [CHAR_W-1:0]  digit_char;
   logic               cnt_one;
   logic               show;
   logic               counted;
   logic [COUNT_W-1:0] ndig_next;
   logic               can_load;
   logic               wr;
   logic               load_neg;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? dig_ff[4*i +: 4] + 4'd3
                                                    : dig_ff[4*i +: 4];
      end
   end

   assign digit      = bin_mode_ff ? {3'b000, dig_ff[BCD_W-1]} : dig_ff[BCD_W-1 -: 4];
   assign digit_char = (digit >= HEX_TEN) ? CHAR_A_LC + {3'b000, digit - HEX_TEN}
                                          : CHAR_ZERO + {3'b000, digit};
   assign cnt_one    = (cnt_ff == 6'd1);
   assign show       = bin_mode_ff || on_ff || (digit != 4'd0) || cnt_one;
   assign counted    = !bin_mode_ff && (on_ff || (digit != 4'd0));
   assign ndig_next  = ndig_ff + {3'b000, counted};
   assign can_load   = !out_valid_ff || rsp_ready;
   assign load_neg   = (req_func == FMT_SDEC) && req_value[VALUE_W-1];

   always_comb begin
      bin_in       = bin_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      bin_mode_in  = bin_mode_ff;
      on_in        = on_ff;
      ndig_in      = ndig_ff;
      neg_in       = neg_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_count_in = out_count_ff;
      wr           = 1'b0;

      if (cmd.load) begin
         neg_in      = load_neg;
         bin_in      = load_neg ? (~req_value + 32'd1) : req_value;
         bin_mode_in = (req_func == FMT_BIN);
         on_in       = 1'b0;
         ndig_in     = '0;
         if (req_func == FMT_SDEC || req_func == FMT_UDEC) begin
            dig_in = '0;
            cnt_in = CNT_CONV;
         end else begin
            dig_in = {req_value, 8'h00};
            cnt_in = (req_func == FMT_BIN) ? CNT_BIN : CNT_HEX;
         end
      end else if (cmd.conv) begin
         dig_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_one ? CNT_DEC : cnt_ff - 6'd1;
      end

      unique case (cmd.emit_kind)
         EMIT_NONE: begin
         end
         EMIT_ZERO: begin
            wr           = 1'b1;
            out_char_in  = CHAR_ZERO;
            out_last_in  = 1'b0;
            out_count_in = '0;
         end
         EMIT_X: begin
            wr           = 1'b1;
            out_char_in  = CHAR_X_LC;
            out_last_in  = 1'b0;
            out_count_in = '0;
         end
         EMIT_MINUS: begin
            wr           = 1'b1;
            out_char_in  = CHAR_MINUS;
            out_last_in  = 1'b0;
            out_count_in = '0;
         end
         EMIT_DIGIT: begin
            wr           = show;
            out_char_in  = digit_char;
            out_last_in  = cnt_one;
            out_count_in = cnt_one ? ndig_next : '0;
            dig_in       = bin_mode_ff ? {dig_ff[BCD_W-2:0], 1'b0}
                                       : {dig_ff[BCD_W-5:0], 4'h0};
            cnt_in       = cnt_ff - 6'd1;
            on_in        = on_ff || (digit != 4'd0);
            ndig_in      = ndig_next;
         end
         default: begin
         end
      endcase

      out_valid_in = wr ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      bin_mode_ff <= bin_mode_in;
      on_ff       <= on_in;
      ndig_ff     <= ndig_in;
      neg_ff      <= neg_in;
      if (wr) begin
         out_char_ff  <= out_char_in;
         out_last_ff  <= out_last_in;
         out_count_ff <= out_count_in;
      end
   end

   assign sts.can_load    = can_load;
   assign sts.cnt_one     = cnt_one;
   assign sts.neg         = neg_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_character   = out_char_ff;
   assign rsp_is_last     = out_last_ff;
   assign rsp_digit_count = out_count_ff;

`ifndef ASSERT_OFF
   a_count_only_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_last_ff |-> out_count_ff == '0)
      else $error("Digit count set on a character that is not the last.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_count_ff <= 4'd10)
      else $error("Digit count exceeds ten.");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_kind != EMIT_NONE |-> can_load)
      else $error("Character emitted while the output register is held.");

   a_counter_live: assert property (@(posedge clock) disable iff (reset)
      cmd.conv || cmd.emit_kind == EMIT_DIGIT |-> cnt_ff != '0)
      else $error("Step counter exhausted during conversion or digit output.");
`endif

endmodule

// ===== src/integer_to_ascii_formatter_core.sv =====
// Integer-to-ASCII formatter, top level: joins the controller and the datapath
// to the request and response channels. Depends on itoa_pkg, itoa_req_if,
// itoa_rsp_if, itoa_ctrl and itoa_dp.
//
// Each request (format code and 32-bit value) produces its text one character
// per response, the last one flagged and carrying the count of significant
// digits (zero for binary). Requests are handled one at a time; a new one is
// taken once the previous one's final character has entered the output
// register. Binary and hex step over every digit position, hex suppressing
// leading zeros without skipping their steps (after the "0x" prefix if asked
// for); decimal digits follow the 32-step double-dabble conversion and, for a
// negative signed value, a minus sign. Each character waits for the output
// register to be free. Codes 5 to 7 are accepted and produce no response.
module integer_to_ascii_formatter_core (
   input logic         clock,
   input logic         reset,
   itoa_req_if.sink    req_ch,
   itoa_rsp_if.source  rsp_ch
);
   import itoa_pkg::*;

   itoa_cmd_type cmd;
   itoa_sts_type sts;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   itoa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_ch.func),
      .req_value       (req_ch.value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_character   (rsp_ch.character),
      .rsp_is_last     (rsp_ch.is_last),
      .rsp_digit_count (rsp_ch.digit_count)
   );

endmodule
